FILE: rtl/core/wrap_diffuse_subsurface_shader_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wrapped diffuse subsurface shader
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef WRAP_DIFFUSE_SUBSURFACE_SHADER_DEFINES_SVH
`define WRAP_DIFFUSE_SUBSURFACE_SHADER_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define DSS_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dss check failed");

// Next-cycle implication, disabled while rst is high.
`define DSS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dss check failed");

`endif

FILE: rtl/core/dss_pkg.sv
// ----------------------------------------------------------------------------
// Diffuse subsurface shader package
// Types, stage schedule and per-stage datapath functions.
// ----------------------------------------------------------------------------
`default_nettype none

package dss_pkg;

   localparam int NUM_STAGES     = 23;
   localparam int ST_PREP        = 1;
   localparam int ST_SQRT_FIRST  = 2;
   localparam int ST_SQRT_LAST   = 9;
   localparam int ST_EXP_FIRST   = 2;
   localparam int ST_EXP_LAST    = 13;
   localparam int ST_DIV1_SETUP  = 10;
   localparam int ST_DIV1_FIRST  = 11;
   localparam int ST_DIV1_LAST   = 14;
   localparam int ST_LIGHT       = 14;
   localparam int ST_DIV2_SETUP  = 15;
   localparam int ST_DIV2_FIRST  = 16;
   localparam int ST_DIV2_LAST   = 19;
   localparam int ST_WRAP        = 20;
   localparam int ST_DIRECT      = 21;
   localparam int ST_TOTAL       = 22;

   localparam logic [14:0] ONE_Q14 = 15'd16384;
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
   localparam logic [11:0] EXP_LIMIT = 12'd4095;

   // exp(-2^(k-8)) in Q1.30 for bit k of a Q8.8 argument.
   localparam logic [29:0] EXP_TBL [12] = '{
      30'd1069555701, 30'd1065385900, 30'd1057095000, 30'd1040706261,
      30'd1008687096, 30'd947573834,  30'd836230973,  30'd651257337,
      30'd395007542,  30'd145315154,  30'd19666268,   30'd360200
   };

   typedef struct packed {
      logic [14:0] scatter_wrap;
      logic [14:0] transmission_max;
      logic [15:0] falloff_per_meter;
      logic [13:0] ambient_floor;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic signed [15:0] light_x;
      logic signed [15:0] light_y;
      logic signed [15:0] light_z;
      logic               two_sided;
      logic               back_face;
      logic signed [15:0] thickness;
      logic signed [15:0] interior_depth;
      logic signed [15:0] shadow_factor;
   } req_type;

   typedef struct packed {
      logic signed [15:0] sx;
      logic signed [15:0] sy;
      logic signed [15:0] sz;
      logic signed [33:0] dot;
      logic [31:0]        nn;
      logic [31:0]        ll;
      logic               zero;
      logic [63:0]        rad;
      logic [31:0]        root;
      logic [35:0]        srem;
      logic               neg;
      logic [47:0]        drem;
      logic [33:0]        ddiv;
      logic [14:0]        quo;
      logic               numneg;
      logic [14:0]        wrap;
      logic [30:0]        fd_prod;
      logic [14:0]        th;
      logic [11:0]        arg_t;
      logic [11:0]        arg_i;
      logic [30:0]        acc_t;
      logic [30:0]        acc_i;
      logic [14:0]        shinv;
      logic [14:0]        trans;
      logic [14:0]        inter;
      logic [14:0]        direct;
      logic [15:0]        total;
   } work_type;

   function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
      if (v == 16'sh8000) begin
         return 16'sh7fff;
      end
      return -v;
   endfunction

   // One rounded Q1.30 multiply by a table entry.
   function automatic logic [30:0] exp_mul(input logic [30:0] acc, input logic [3:0] idx);
      logic [61:0] p;
      p = 62'(acc) * 62'(EXP_TBL[idx]) + 62'd536870912;
      return p[60:30];
   endfunction

   // Stage zero: flip, clamps and the vector products.
   function automatic work_type front(input req_type q, input cfg_type c);
      work_type           r;
      logic               flip;
      logic signed [33:0] tnn;
      logic signed [33:0] tll;
      logic [14:0]        dep;
      logic [14:0]        s;
      r    = '0;
      flip = q.two_sided & q.back_face;
      r.sx = flip ? neg_sat(q.normal_x) : q.normal_x;
      r.sy = flip ? neg_sat(q.normal_y) : q.normal_y;
      r.sz = flip ? neg_sat(q.normal_z) : q.normal_z;
      r.dot = r.sx * q.light_x + r.sy * q.light_y + r.sz * q.light_z;
      tnn  = r.sx * r.sx + r.sy * r.sy + r.sz * r.sz;
      tll  = q.light_x * q.light_x + q.light_y * q.light_y + q.light_z * q.light_z;
      r.nn = tnn[31:0];
      r.ll = tll[31:0];
      r.th = q.thickness[15] ? 15'd0 : q.thickness[14:0];
      dep  = q.interior_depth[15] ? 15'd0 : q.interior_depth[14:0];
      r.fd_prod = 31'(c.falloff_per_meter) * 31'(dep);
      if (q.shadow_factor[15]) begin
         s = 15'd0;
      end else if (q.shadow_factor[14:0] > ONE_Q14) begin
         s = ONE_Q14;
      end else begin
         s = q.shadow_factor[14:0];
      end
      r.shinv = ONE_Q14 - s;
      return r;
   endfunction

   // Work done in front of stage register k (k of one and above).
   function automatic work_type stage_step(input int k, input work_type w, input cfg_type c);
      work_type           r;
      logic [31:0]        t32;
      logic [35:0]        t36;
      logic [35:0]        trial;
      logic [47:0]        t48;
      logic [45:0]        p46;
      logic [30:0]        p31;
      logic [33:0]        mag;
      logic [14:0]        q;
      logic signed [16:0] num;
      logic [15:0]        dden;
      int                 top;
      int                 bi;
      int                 b;
      r = w;
      if (k == ST_PREP) begin
         r.rad  = w.nn * w.ll;
         r.zero = (w.nn == 32'd0) || (w.ll == 32'd0);
         r.root = '0;
         r.srem = '0;
         r.arg_t = w.th[11:0];
         r.acc_t = (w.th > 15'(EXP_LIMIT)) ? 31'd0 : ONE_Q30;
         t32 = {1'b0, w.fd_prod} + 32'd128;
         r.arg_i = t32[19:8];
         r.acc_i = (t32[31:8] > 24'(EXP_LIMIT)) ? 31'd0 : ONE_Q30;
      end
      if (k inside {[ST_SQRT_FIRST:ST_SQRT_LAST]}) begin
         // Four root bits per stage, two radicand bits each.
         for (int j = 0; j < 4; j++) begin
            t36   = {r.srem[33:0], r.rad[63:62]};
            r.rad = r.rad << 2;
            trial = {2'b00, r.root, 2'b01};
            if (t36 >= trial) begin
               r.srem = t36 - trial;
               r.root = {r.root[30:0], 1'b1};
            end else begin
               r.srem = t36;
               r.root = {r.root[30:0], 1'b0};
            end
         end
      end
      if (k inside {[ST_EXP_FIRST:ST_EXP_LAST]}) begin
         b = k - ST_EXP_FIRST;
         if (r.arg_t[4'(b)]) begin
            r.acc_t = exp_mul(r.acc_t, 4'(b));
         end
         if (r.arg_i[4'(b)]) begin
            r.acc_i = exp_mul(r.acc_i, 4'(b));
         end
      end
      if (k == ST_DIV1_SETUP) begin
         r.neg  = w.dot[33];
         mag    = w.dot[33] ? 34'(-w.dot) : 34'(w.dot);
         r.zero = w.zero || (w.root == 32'd0);
         r.drem = {mag[32:0], 15'd0} + {16'd0, w.root};
         r.ddiv = {1'b0, w.root, 1'b0};
         r.quo  = '0;
      end
      if (k inside {[ST_DIV1_FIRST:ST_DIV1_LAST], [ST_DIV2_FIRST:ST_DIV2_LAST]}) begin
         // Restoring division, four quotient bits per stage.
         if (k <= ST_DIV1_LAST) begin
            top = 14 - 4 * (k - ST_DIV1_FIRST);
         end else begin
            top = 14 - 4 * (k - ST_DIV2_FIRST);
         end
         for (int j = 0; j < 4; j++) begin
            bi = top - j;
            if (bi >= 0) begin
               t48 = {14'd0, r.ddiv} << bi;
               if (r.drem >= t48) begin
                  r.drem = r.drem - t48;
                  r.quo  = r.quo | (15'd1 << bi);
               end
            end
         end
      end
      if (k == ST_LIGHT) begin
         p46 = 46'(c.transmission_max) * 46'(w.acc_t) + 46'd536870912;
         r.trans = p46[44:30];
         p46 = 46'(ONE_Q14 - {1'b0, c.ambient_floor}) * 46'(w.acc_i) + 46'd536870912;
         r.inter = {1'b0, c.ambient_floor} + p46[44:30];
      end
      if (k == ST_DIV2_SETUP) begin
         q      = (w.quo > ONE_Q14) ? ONE_Q14 : w.quo;
         num    = w.neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
         num    = num + $signed({2'b00, c.scatter_wrap});
         r.numneg = (num <= 17'sd0);
         dden   = 16'd16384 + {1'b0, c.scatter_wrap};
         r.drem = {2'd0, num[15:0], 15'd0} + {32'd0, dden};
         r.ddiv = {17'd0, dden, 1'b0};
         r.quo  = '0;
      end
      if (k == ST_WRAP) begin
         if (w.zero || w.numneg) begin
            r.wrap = '0;
         end else begin
            r.wrap = (w.quo > ONE_Q14) ? ONE_Q14 : w.quo;
         end
      end
      if (k == ST_DIRECT) begin
         p31 = 31'(w.wrap) * 31'(w.shinv) + 31'd8192;
         r.direct = p31[28:14];
      end
      if (k == ST_TOTAL) begin
         r.total = {1'b0, w.direct} + {1'b0, w.inter};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/dss_cfg.sv
// ----------------------------------------------------------------------------
// Shader configuration registers
// APB-style register file holding the four material settings.
// ----------------------------------------------------------------------------
`default_nettype none

module dss_cfg (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_psel,
   input  wire logic            csr_penable,
   input  wire logic            csr_pwrite,
   input  wire logic [3:0]      csr_paddr,
   input  wire logic [31:0]     csr_pwdata,
   output logic      [31:0]     csr_prdata,
   output logic                 csr_pready,
   output dss_pkg::cfg_type     cfg
);

   localparam logic [1:0] REG_SCATTER_WRAP = 2'd0;
   localparam logic [1:0] REG_TRANS_MAX    = 2'd1;
   localparam logic [1:0] REG_FALLOFF      = 2'd2;
   localparam logic [1:0] REG_AMB_FLOOR    = 2'd3;

   dss_pkg::cfg_type cfg_ff;
   dss_pkg::cfg_type cfg_in;
   logic             wr_en;
   logic [14:0]      wr_q14;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   // Unit registers saturate at one.
   assign wr_q14     = (csr_pwdata[14:0] > dss_pkg::ONE_Q14) ? dss_pkg::ONE_Q14
                                                             : csr_pwdata[14:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_paddr[3:2])
            REG_SCATTER_WRAP: cfg_in.scatter_wrap      = wr_q14;
            REG_TRANS_MAX:    cfg_in.transmission_max  = wr_q14;
            REG_FALLOFF:      cfg_in.falloff_per_meter = csr_pwdata[15:0];
            REG_AMB_FLOOR:    cfg_in.ambient_floor     = csr_pwdata[13:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_SCATTER_WRAP: csr_prdata = {17'd0, cfg_ff.scatter_wrap};
         REG_TRANS_MAX:    csr_prdata = {17'd0, cfg_ff.transmission_max};
         REG_FALLOFF:      csr_prdata = {16'd0, cfg_ff.falloff_per_meter};
         REG_AMB_FLOOR:    csr_prdata = {18'd0, cfg_ff.ambient_floor};
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/core/dss_stage.sv
// ----------------------------------------------------------------------------
// Shader pipeline stage register
// One elastic stage: data register, valid bit and back-pressure chaining.
// ----------------------------------------------------------------------------
`default_nettype none

module dss_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              up_valid,
   output logic                   up_ready,
   input  wire dss_pkg::work_type up_data,
   output logic                   dn_valid,
   input  wire logic              dn_ready,
   output dss_pkg::work_type      dn_data
);

   logic              valid_ff;
   dss_pkg::work_type data_ff;

   // The stage takes new work when empty or when its content moves on.
   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= up_data;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/wrap_diffuse_subsurface_shader.sv
// ----------------------------------------------------------------------------
// Wrapped diffuse subsurface shader
// Per-sample wrapped diffuse, transmission and interior ambient shading.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ stream, one shading sample per request, and
// each one yields exactly one response on the rsp_ stream, in order.
// The csr_ port holds four material registers; write them only while the
// pipeline is empty.
// The block takes one request every cycle while the receiver does not
// stall the responses. The path is a 23-stage pipeline: the square root of
// |n|^2*|l|^2 resolves four root bits per stage over eight stages, each
// of the two dividers resolves four quotient bits per stage, and each
// exponential applies one table multiply per stage over twelve stages.
// Reset clears every stage valid bit and the material registers to zero; no request
// in flight survives it.
// When the receiver stalls, finished responses are held and the stages
// behind them keep filling; bubbles close up, so requests are still taken
// until every stage is full, and nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module wrap_diffuse_subsurface_shader (
   input  wire logic          clock,
   input  wire logic          reset,
   // Request stream.
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // tdata from bit 0: normal_x, normal_y, normal_z, light_x, light_y,
   // light_z, thickness, interior_depth, shadow_factor (16 bits each).
   input  wire logic [143:0]  req_tdata,
   // tuser from bit 0: two_sided, back_face.
   input  wire logic [1:0]    req_tuser,
   // Response stream.
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // tdata from bit 0: shade_normal_x, shade_normal_y, shade_normal_z
   // (16 each), wrap_diffuse, transmission, interior_light, direct_diffuse
   // (15 each), total_light (16), then four zero bits.
   output logic [127:0]       rsp_tdata,
   // Configuration port.
   input  wire logic          csr_psel,
   input  wire logic          csr_penable,
   input  wire logic          csr_pwrite,
   input  wire logic [3:0]    csr_paddr,
   input  wire logic [31:0]   csr_pwdata,
   output logic      [31:0]   csr_prdata,
   output logic               csr_pready
);

   localparam int NS = dss_pkg::NUM_STAGES;

   dss_pkg::cfg_type  cfg;
   dss_pkg::req_type  req;
   dss_pkg::work_type stage_next [NS];
   dss_pkg::work_type stage_data [NS];
   logic              stage_valid [NS];
   logic              stage_ready [NS];
   logic              stage_in_valid [NS];
   logic              stage_dn_ready [NS];

   dss_cfg u_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Unpack the request fields.
   always_comb begin
      req.normal_x       = req_tdata[15:0];
      req.normal_y       = req_tdata[31:16];
      req.normal_z       = req_tdata[47:32];
      req.light_x        = req_tdata[63:48];
      req.light_y        = req_tdata[79:64];
      req.light_z        = req_tdata[95:80];
      req.thickness      = req_tdata[111:96];
      req.interior_depth = req_tdata[127:112];
      req.shadow_factor  = req_tdata[143:128];
      req.two_sided      = req_tuser[0];
      req.back_face      = req_tuser[1];
   end

   // Stage zero forms the products; each later stage applies its slice of
   // the schedule to the register in front of it.
   assign stage_next[0]     = dss_pkg::front(req, cfg);
   assign stage_in_valid[0] = req_tvalid;

   for (genvar g = 1; g < NS; g++) begin : g_next
      assign stage_next[g]     = dss_pkg::stage_step(g, stage_data[g-1], cfg);
      assign stage_in_valid[g] = stage_valid[g-1];
   end

   for (genvar g = 0; g < NS; g++) begin : g_stage
      if (g == NS - 1) begin : g_last
         assign stage_dn_ready[g] = rsp_tready;
      end else begin : g_mid
         assign stage_dn_ready[g] = stage_ready[g+1];
      end

      dss_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .up_valid (stage_in_valid[g]),
         .up_ready (stage_ready[g]),
         .up_data  (stage_next[g]),
         .dn_valid (stage_valid[g]),
         .dn_ready (stage_dn_ready[g]),
         .dn_data  (stage_data[g])
      );
   end

   assign req_tready = stage_ready[0];
   assign rsp_tvalid = stage_valid[NS-1];
   assign rsp_tdata  = {4'd0,
                        stage_data[NS-1].total,
                        stage_data[NS-1].direct,
                        stage_data[NS-1].inter,
                        stage_data[NS-1].trans,
                        stage_data[NS-1].wrap,
                        stage_data[NS-1].sz,
                        stage_data[NS-1].sy,
                        stage_data[NS-1].sx};

endmodule

`default_nettype wire

FILE: rtl/core/dss_checker.sv
// ----------------------------------------------------------------------------
// Shader port checker
// Concurrent checks on the top-level ports, bound to the shader.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wrap_diffuse_subsurface_shader_defines.svh"

module dss_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [127:0] rsp_tdata
);

   // Reset empties the pipeline.
   `DSS_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_tvalid)

   // A stalled response holds.
   `DSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // With the output free, back-pressure never reaches the input.
   `DSS_ASSERT_SAME(a_ready_when_free, clock, reset, !rsp_tvalid || rsp_tready, req_tready)

   // Wrapped diffuse stays within one.
   `DSS_ASSERT_SAME(a_wrap_range, clock, reset, rsp_tvalid, rsp_tdata[62:48] <= 15'd16384)

   // Total light is direct plus interior.
   `DSS_ASSERT_SAME(a_total_sum, clock, reset, rsp_tvalid, rsp_tdata[123:108] == (16'(rsp_tdata[107:93]) + 16'(rsp_tdata[92:78])))

endmodule

bind wrap_diffuse_subsurface_shader dss_checker u_dss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
